[rtl/ssrm_pkg.sv]
// shared constants, codes and types for the segment slot ring manager
// no dependencies; used by every module of the block
package ssrm_pkg;

   localparam int unsigned SLOT_COUNT_DEF = 3;

   localparam int unsigned ACTION_W = 3;
   localparam int unsigned SLOT_W   = 4;
   localparam int unsigned FRAME_W  = 24;
   localparam int unsigned TAG_W    = 16;
   localparam int unsigned STATUS_W = 2;

   localparam logic [TAG_W-1:0] SEG_TOTAL_RESET = 16'd1;

   // command codes
   localparam logic [ACTION_W-1:0] ACT_MARK    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_CONSUME = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_ADVANCE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_SEEK    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_RESET   = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_END     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD_IDX = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the incoming request beat
      logic execute;   // apply the command to the slot ring
      logic publish;   // load the result register
   } ctl_cmd_type;

endpackage

[rtl/ssrm_ctrl.sv]
// sequencing state machine of the segment slot ring manager
// depends on ssrm_pkg
module ssrm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ssrm_pkg::ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EXEC   = 3'b010,
      ST_RESULT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               req_stall    = 1'b0;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/ssrm_datapath.sv]
// slot ring storage, command execution and result register
// depends on ssrm_pkg; driven by ssrm_ctrl commands
module ssrm_datapath #(
   parameter int unsigned SLOT_COUNT = ssrm_pkg::SLOT_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ssrm_pkg::ctl_cmd_type          cmd,
   input  logic                           csr_write_enable,
   input  logic [ssrm_pkg::TAG_W-1:0]     csr_write_data,
   input  logic [ssrm_pkg::ACTION_W-1:0]  req_action,
   input  logic [ssrm_pkg::SLOT_W-1:0]    req_slot_index,
   input  logic [ssrm_pkg::FRAME_W-1:0]   req_frame_count_in,
   input  logic [ssrm_pkg::TAG_W-1:0]     req_segment_tag_in,
   input  logic                           req_last_flag,
   input  logic [ssrm_pkg::FRAME_W-1:0]   req_frames_used,
   input  logic [ssrm_pkg::TAG_W-1:0]     req_target_segment,
   output logic [ssrm_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ssrm_pkg::SLOT_W-1:0]    rsp_freed_slot,
   output logic                           rsp_free_found,
   output logic [ssrm_pkg::SLOT_W-1:0]    rsp_free_slot,
   output logic                           rsp_current_valid,
   output logic                           rsp_current_done,
   output logic [ssrm_pkg::FRAME_W-1:0]   rsp_current_remaining,
   output logic                           rsp_current_is_last,
   output logic [ssrm_pkg::TAG_W-1:0]     rsp_current_tag,
   output logic [ssrm_pkg::TAG_W-1:0]     rsp_current_segment_number
);

   localparam int unsigned IDX_W   = $clog2(SLOT_COUNT);
   localparam int unsigned FRAME_W = ssrm_pkg::FRAME_W;
   localparam int unsigned TAG_W   = ssrm_pkg::TAG_W;
   localparam int unsigned SLOT_W  = ssrm_pkg::SLOT_W;

   // captured request beat
   logic [ssrm_pkg::ACTION_W-1:0] act_ff;
   logic [SLOT_W-1:0]             sidx_ff;
   logic [FRAME_W-1:0]            fcount_ff;
   logic [TAG_W-1:0]              tag_in_ff;
   logic                          last_in_ff;
   logic [FRAME_W-1:0]            used_ff;
   logic [TAG_W-1:0]              target_ff;

   // slot ring
   logic [SLOT_COUNT-1:0]         valid_ff, valid_in;
   logic [SLOT_COUNT-1:0]         last_ff, last_in;
   logic [FRAME_W-1:0]            frames_ff [SLOT_COUNT];
   logic [FRAME_W-1:0]            frames_in [SLOT_COUNT];
   logic [FRAME_W-1:0]            consumed_ff [SLOT_COUNT];
   logic [FRAME_W-1:0]            consumed_in [SLOT_COUNT];
   logic [TAG_W-1:0]              stag_ff [SLOT_COUNT];
   logic [TAG_W-1:0]              stag_in [SLOT_COUNT];
   logic [IDX_W-1:0]              cur_ff, cur_in;
   logic [TAG_W-1:0]              seg_ff, seg_in;
   logic [TAG_W-1:0]              total_ff;
   logic [ssrm_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [SLOT_W-1:0]             freed_ff, freed_in;

   logic [FRAME_W:0]              sum_used;
   logic                          sidx_ok;
   logic                          at_end;
   logic [IDX_W-1:0]              widx;

   logic                          cur_valid;
   logic [FRAME_W-1:0]            cur_frames;
   logic [FRAME_W-1:0]            cur_consumed;
   logic                          found;
   logic [IDX_W-1:0]              fslot;

   assign sum_used = {1'b0, consumed_ff[cur_ff]} + {1'b0, used_ff};
   assign sidx_ok  = {1'b0, sidx_ff} < (SLOT_W+1)'(SLOT_COUNT);
   assign widx     = sidx_ff[IDX_W-1:0];
   assign at_end   = ({1'b0, seg_ff} + 17'd1) >= {1'b0, total_ff};

   // command execution
   always_comb begin
      valid_in    = valid_ff;
      last_in     = last_ff;
      frames_in   = frames_ff;
      consumed_in = consumed_ff;
      stag_in     = stag_ff;
      cur_in      = cur_ff;
      seg_in      = seg_ff;
      status_in   = ssrm_pkg::STAT_OK;
      freed_in    = '0;
      case (act_ff)
         ssrm_pkg::ACT_MARK: begin
            if (sidx_ok) begin
               valid_in[widx]    = 1'b1;
               last_in[widx]     = last_in_ff;
               frames_in[widx]   = fcount_ff;
               consumed_in[widx] = '0;
               stag_in[widx]     = tag_in_ff;
            end else begin
               status_in = ssrm_pkg::STAT_BAD_IDX;
            end
         end
         ssrm_pkg::ACT_CONSUME: begin
            if (valid_ff[cur_ff]) begin
               consumed_in[cur_ff] = sum_used[FRAME_W] ? '1 : sum_used[FRAME_W-1:0];
            end
         end
         ssrm_pkg::ACT_ADVANCE: begin
            if (at_end) begin
               status_in = ssrm_pkg::STAT_END;
            end else begin
               valid_in[cur_ff] = 1'b0;
               freed_in         = SLOT_W'(cur_ff);
               cur_in           = (cur_ff == IDX_W'(SLOT_COUNT - 1)) ? '0 : cur_ff + 1'b1;
               seg_in           = seg_ff + 1'b1;
            end
         end
         ssrm_pkg::ACT_SEEK: begin
            valid_in = '0;
            cur_in   = '0;
            seg_in   = target_ff;
         end
         ssrm_pkg::ACT_RESET: begin
            valid_in = '0;
            cur_in   = '0;
            seg_in   = '0;
         end
         default: begin
         end
      endcase
   end

   // report of the current slot and nearest free slot
   assign cur_valid    = valid_ff[cur_ff];
   assign cur_frames   = frames_ff[cur_ff];
   assign cur_consumed = consumed_ff[cur_ff];

   always_comb begin
      logic [IDX_W:0] probe;
      found = 1'b0;
      fslot = '0;
      probe = '0;
      for (int off = SLOT_COUNT - 1; off >= 1; off--) begin
         probe = {1'b0, cur_ff} + (IDX_W+1)'(off);
         if (probe >= (IDX_W+1)'(SLOT_COUNT)) begin
            probe = probe - (IDX_W+1)'(SLOT_COUNT);
         end
         if (!valid_ff[probe[IDX_W-1:0]]) begin
            found = 1'b1;
            fslot = probe[IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff     <= req_action;
         sidx_ff    <= req_slot_index;
         fcount_ff  <= req_frame_count_in;
         tag_in_ff  <= req_segment_tag_in;
         last_in_ff <= req_last_flag;
         used_ff    <= req_frames_used;
         target_ff  <= req_target_segment;
      end
      if (cmd.execute) begin
         last_ff     <= last_in;
         frames_ff   <= frames_in;
         consumed_ff <= consumed_in;
         stag_ff     <= stag_in;
         status_ff   <= status_in;
         freed_ff    <= freed_in;
      end
      if (cmd.publish) begin
         rsp_status                 <= status_ff;
         rsp_freed_slot             <= freed_ff;
         rsp_free_found             <= found;
         rsp_free_slot              <= SLOT_W'(fslot);
         rsp_current_valid          <= cur_valid;
         rsp_current_done           <= !cur_valid || (cur_consumed >= cur_frames);
         rsp_current_remaining      <= (cur_valid && (cur_frames > cur_consumed))
                                       ? cur_frames - cur_consumed : '0;
         rsp_current_is_last        <= cur_valid && last_ff[cur_ff];
         rsp_current_tag            <= cur_valid ? stag_ff[cur_ff] : '0;
         rsp_current_segment_number <= seg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cur_ff   <= '0;
         seg_ff   <= '0;
         total_ff <= ssrm_pkg::SEG_TOTAL_RESET;
      end else begin
         if (cmd.execute) begin
            valid_ff <= valid_in;
            cur_ff   <= cur_in;
            seg_ff   <= seg_in;
         end
         if (csr_write_enable) begin
            total_ff <= csr_write_data;
         end
      end
   end

endmodule

[rtl/segment_slot_ring_manager_core.sv]
// top level of the segment slot ring manager
// depends on ssrm_pkg, ssrm_ctrl and ssrm_datapath
//
// channel   ports                          direction  content
// ------    -----------------------------  ---------  ---------------------------------
// request   req_valid / req_stall, req_*   in         one command beat
// response  rsp_valid / rsp_stall, rsp_*   out        one status beat per command
// config    csr_write_enable, csr_write_data  in      segment count of the track
//
// a beat is taken in the idle or result state, applied to the slot ring in the
// execute state, and its result registered in the result state, where the next
// beat can be taken; a new beat is not taken before the last one is published
// req_stall is high in the execute cycle, and in the result cycle while a
// response beat held by rsp_stall still occupies the result register
// synchronous active-high reset empties the ring and sets the track length to one
module segment_slot_ring_manager_core #(
   parameter int unsigned SLOT_COUNT = ssrm_pkg::SLOT_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_write_enable,
   input  logic [ssrm_pkg::TAG_W-1:0]     csr_write_data,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ssrm_pkg::ACTION_W-1:0]  req_action,
   input  logic [ssrm_pkg::SLOT_W-1:0]    req_slot_index,
   input  logic [ssrm_pkg::FRAME_W-1:0]   req_frame_count_in,
   input  logic [ssrm_pkg::TAG_W-1:0]     req_segment_tag_in,
   input  logic                           req_last_flag,
   input  logic [ssrm_pkg::FRAME_W-1:0]   req_frames_used,
   input  logic [ssrm_pkg::TAG_W-1:0]     req_target_segment,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ssrm_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ssrm_pkg::SLOT_W-1:0]    rsp_freed_slot,
   output logic                           rsp_free_found,
   output logic [ssrm_pkg::SLOT_W-1:0]    rsp_free_slot,
   output logic                           rsp_current_valid,
   output logic                           rsp_current_done,
   output logic [ssrm_pkg::FRAME_W-1:0]   rsp_current_remaining,
   output logic                           rsp_current_is_last,
   output logic [ssrm_pkg::TAG_W-1:0]     rsp_current_tag,
   output logic [ssrm_pkg::TAG_W-1:0]     rsp_current_segment_number
);

   ssrm_pkg::ctl_cmd_type cmd;

   // sequencer: capture, execute, publish
   ssrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // slot storage, command logic and result register
   ssrm_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock                      (clock),
      .reset                      (reset),
      .cmd                        (cmd),
      .csr_write_enable           (csr_write_enable),
      .csr_write_data             (csr_write_data),
      .req_action                 (req_action),
      .req_slot_index             (req_slot_index),
      .req_frame_count_in         (req_frame_count_in),
      .req_segment_tag_in         (req_segment_tag_in),
      .req_last_flag              (req_last_flag),
      .req_frames_used            (req_frames_used),
      .req_target_segment         (req_target_segment),
      .rsp_status                 (rsp_status),
      .rsp_freed_slot             (rsp_freed_slot),
      .rsp_free_found             (rsp_free_found),
      .rsp_free_slot              (rsp_free_slot),
      .rsp_current_valid          (rsp_current_valid),
      .rsp_current_done           (rsp_current_done),
      .rsp_current_remaining      (rsp_current_remaining),
      .rsp_current_is_last        (rsp_current_is_last),
      .rsp_current_tag            (rsp_current_tag),
      .rsp_current_segment_number (rsp_current_segment_number)
   );

endmodule

[tb/ssrm_checker.sv]
// response checker for the segment slot ring manager: tracks the slot ring
// from the accepted command beats and compares every response beat
// depends on ssrm_pkg; instantiated by tb_top beside the block
module ssrm_checker #(
   parameter int unsigned SLOT_COUNT = ssrm_pkg::SLOT_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [ssrm_pkg::TAG_W-1:0]       csr_write_data,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [ssrm_pkg::ACTION_W-1:0]    req_action,
   input  logic [ssrm_pkg::SLOT_W-1:0]      req_slot_index,
   input  logic [ssrm_pkg::FRAME_W-1:0]     req_frame_count_in,
   input  logic [ssrm_pkg::TAG_W-1:0]       req_segment_tag_in,
   input  logic                             req_last_flag,
   input  logic [ssrm_pkg::FRAME_W-1:0]     req_frames_used,
   input  logic [ssrm_pkg::TAG_W-1:0]       req_target_segment,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [ssrm_pkg::STATUS_W-1:0]    rsp_status,
   input  logic [ssrm_pkg::SLOT_W-1:0]      rsp_freed_slot,
   input  logic                             rsp_free_found,
   input  logic [ssrm_pkg::SLOT_W-1:0]      rsp_free_slot,
   input  logic                             rsp_current_valid,
   input  logic                             rsp_current_done,
   input  logic [ssrm_pkg::FRAME_W-1:0]     rsp_current_remaining,
   input  logic                             rsp_current_is_last,
   input  logic [ssrm_pkg::TAG_W-1:0]       rsp_current_tag,
   input  logic [ssrm_pkg::TAG_W-1:0]       rsp_current_segment_number,
   output int unsigned                      mismatch_count,
   output int unsigned                      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FRAME_W  = ssrm_pkg::FRAME_W;
   localparam int unsigned TAG_W    = ssrm_pkg::TAG_W;
   localparam int unsigned SLOT_W   = ssrm_pkg::SLOT_W;
   localparam int unsigned STATUS_W = ssrm_pkg::STATUS_W;
   localparam int unsigned FIELD_W  = ssrm_pkg::FRAME_W;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   freed_slot;
      logic                free_found;
      logic [SLOT_W-1:0]   free_slot;
      logic                current_valid;
      logic                current_done;
      logic [FRAME_W-1:0]  current_remaining;
      logic                current_is_last;
      logic [TAG_W-1:0]    current_tag;
      logic [TAG_W-1:0]    current_segment_number;
   } slot_report_type;

   // shadow copy of the slot ring
   logic               ring_valid    [SLOT_COUNT];
   logic               ring_last     [SLOT_COUNT];
   logic [FRAME_W-1:0] ring_frames   [SLOT_COUNT];
   logic [FRAME_W-1:0] ring_consumed [SLOT_COUNT];
   logic [TAG_W-1:0]   ring_tag      [SLOT_COUNT];
   int unsigned        play_slot;
   logic [TAG_W-1:0]   play_segment;
   logic [TAG_W-1:0]   track_segments;

   slot_report_type report_q[$];

   task automatic empty_slot(input int unsigned i);
      ring_valid[i]    = 1'b0;
      ring_last[i]     = 1'b0;
      ring_frames[i]   = '0;
      ring_consumed[i] = '0;
      ring_tag[i]      = '0;
   endtask

   task automatic empty_ring();
      for (int unsigned i = 0; i < SLOT_COUNT; i++) empty_slot(i);
      play_slot = 0;
   endtask

   // applies one command to the shadow ring and builds the report it yields
   task automatic play_command(output slot_report_type r);
      logic [FRAME_W:0] total_used;
      int unsigned      idx;
      r = '0;
      case (req_action)
         ssrm_pkg::ACT_MARK: begin
            if (req_slot_index >= SLOT_COUNT) begin
               r.status = ssrm_pkg::STAT_BAD_IDX;
            end else begin
               ring_frames[req_slot_index]   = req_frame_count_in;
               ring_consumed[req_slot_index] = '0;
               ring_tag[req_slot_index]      = req_segment_tag_in;
               ring_last[req_slot_index]     = req_last_flag;
               ring_valid[req_slot_index]    = 1'b1;
            end
         end
         ssrm_pkg::ACT_CONSUME: begin
            if (ring_valid[play_slot] && req_frames_used != '0) begin
               total_used = {1'b0, ring_consumed[play_slot]} + {1'b0, req_frames_used};
               ring_consumed[play_slot] = total_used[FRAME_W] ? '1 : total_used[FRAME_W-1:0];
            end
         end
         ssrm_pkg::ACT_ADVANCE: begin
            if ({1'b0, play_segment} + 17'd1 >= {1'b0, track_segments}) begin
               r.status = ssrm_pkg::STAT_END;
            end else begin
               empty_slot(play_slot);
               r.freed_slot = play_slot[SLOT_W-1:0];
               play_slot    = (play_slot + 1) % SLOT_COUNT;
               play_segment = play_segment + 1'b1;
            end
         end
         ssrm_pkg::ACT_SEEK: begin
            empty_ring();
            play_segment = req_target_segment;
         end
         ssrm_pkg::ACT_RESET: begin
            empty_ring();
            play_segment = '0;
         end
         default: ;
      endcase

      // nearest free slot after the current one
      for (int unsigned off = 1; off < SLOT_COUNT; off++) begin
         idx = (play_slot + off) % SLOT_COUNT;
         if (!ring_valid[idx] && !r.free_found) begin
            r.free_found = 1'b1;
            r.free_slot  = idx[SLOT_W-1:0];
         end
      end

      r.current_valid = ring_valid[play_slot];
      if (ring_valid[play_slot]) begin
         r.current_done      = ring_consumed[play_slot] >= ring_frames[play_slot];
         r.current_remaining = ring_frames[play_slot] > ring_consumed[play_slot] ?
                               ring_frames[play_slot] - ring_consumed[play_slot] : '0;
         r.current_is_last   = ring_last[play_slot];
         r.current_tag       = ring_tag[play_slot];
      end else begin
         r.current_done = 1'b1;
      end
      r.current_segment_number = play_segment;
   endtask

   task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                              input logic [FIELD_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      slot_report_type want;
      if (reset) begin
         empty_ring();
         play_segment   = '0;
         track_segments = ssrm_pkg::SEG_TOTAL_RESET;
         mismatch_count = 0;
         report_q.delete();
      end else begin
         if (csr_write_enable) track_segments = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            if (report_q.size() == 0) begin
               $error("response beat with no command waiting");
               mismatch_count++;
            end else begin
               want = report_q.pop_front();
               check_field("status", FIELD_W'(want.status), FIELD_W'(rsp_status));
               check_field("freed_slot", FIELD_W'(want.freed_slot),
                           FIELD_W'(rsp_freed_slot));
               check_field("free_found", FIELD_W'(want.free_found),
                           FIELD_W'(rsp_free_found));
               check_field("free_slot", FIELD_W'(want.free_slot), FIELD_W'(rsp_free_slot));
               check_field("current_valid", FIELD_W'(want.current_valid),
                           FIELD_W'(rsp_current_valid));
               check_field("current_done", FIELD_W'(want.current_done),
                           FIELD_W'(rsp_current_done));
               check_field("current_remaining", want.current_remaining,
                           rsp_current_remaining);
               check_field("current_is_last", FIELD_W'(want.current_is_last),
                           FIELD_W'(rsp_current_is_last));
               check_field("current_tag", FIELD_W'(want.current_tag),
                           FIELD_W'(rsp_current_tag));
               check_field("current_segment_number",
                           FIELD_W'(want.current_segment_number),
                           FIELD_W'(rsp_current_segment_number));
            end
         end
         if (req_valid && !req_stall) begin
            play_command(want);
            report_q.push_back(want);
         end
      end
      pending_count <= unsigned'(report_q.size());
   end

endmodule

[tb/tb_top.sv]
// top of the segment slot ring manager testbench: clock, reset, command and
// config stimulus, response back-pressure and the final verdict
// depends on ssrm_pkg, segment_slot_ring_manager_core and ssrm_checker
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ACTION_W = ssrm_pkg::ACTION_W;
   localparam int unsigned SLOT_W   = ssrm_pkg::SLOT_W;
   localparam int unsigned FRAME_W  = ssrm_pkg::FRAME_W;
   localparam int unsigned TAG_W    = ssrm_pkg::TAG_W;
   localparam int unsigned STATUS_W = ssrm_pkg::STATUS_W;

   // generous bound: ~1200 beats, plus holds
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned PHASE_BEATS  = 190;
   localparam int unsigned LONG_HOLD    = 150;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [SLOT_W-1:0]   slot_index;
      logic [FRAME_W-1:0]  frame_count_in;
      logic [TAG_W-1:0]    segment_tag_in;
      logic                last_flag;
      logic [FRAME_W-1:0]  frames_used;
      logic [TAG_W-1:0]    target_segment;
   } ring_cmd_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [TAG_W-1:0]      csr_write_data;
   logic                  req_valid;
   logic                  req_stall;
   logic [ACTION_W-1:0]   req_action;
   logic [SLOT_W-1:0]     req_slot_index;
   logic [FRAME_W-1:0]    req_frame_count_in;
   logic [TAG_W-1:0]      req_segment_tag_in;
   logic                  req_last_flag;
   logic [FRAME_W-1:0]    req_frames_used;
   logic [TAG_W-1:0]      req_target_segment;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_W-1:0]     rsp_freed_slot;
   logic                  rsp_free_found;
   logic [SLOT_W-1:0]     rsp_free_slot;
   logic                  rsp_current_valid;
   logic                  rsp_current_done;
   logic [FRAME_W-1:0]    rsp_current_remaining;
   logic                  rsp_current_is_last;
   logic [TAG_W-1:0]      rsp_current_tag;
   logic [TAG_W-1:0]      rsp_current_segment_number;
   int unsigned           mismatch_count;
   int unsigned           pending_count;

   // sender burst bookkeeping and long-hold requests to the receiver
   int unsigned           burst_left;
   int unsigned           long_hold_requests;
   int unsigned           cycle_count;

   segment_slot_ring_manager_core i_dut (.*);

   ssrm_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic ring_cmd_type cmd_of(input logic [ACTION_W-1:0] act,
                                           input logic [SLOT_W-1:0] sidx,
                                           input logic [FRAME_W-1:0] frames,
                                           input logic [TAG_W-1:0] tag,
                                           input logic last,
                                           input logic [FRAME_W-1:0] used,
                                           input logic [TAG_W-1:0] target);
      ring_cmd_type c;
      c.action         = act;
      c.slot_index     = sidx;
      c.frame_count_in = frames;
      c.segment_tag_in = tag;
      c.last_flag      = last;
      c.frames_used    = used;
      c.target_segment = target;
      return c;
   endfunction

   // mostly playback-like traffic: fill slots, eat frames, move on;
   // the rest is seeks, resets, bad slot indexes and unused codes
   function automatic ring_cmd_type playback_cmd(input logic [TAG_W-1:0] total);
      ring_cmd_type c;
      int unsigned  pick;
      // irrelevant fields carry random noise
      c.action         = ACTION_W'($urandom_range(0, 7));
      c.slot_index     = SLOT_W'($urandom);
      c.frame_count_in = FRAME_W'($urandom);
      c.segment_tag_in = TAG_W'($urandom);
      c.last_flag      = 1'($urandom);
      c.frames_used    = FRAME_W'($urandom);
      c.target_segment = TAG_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         c.action     = ssrm_pkg::ACT_MARK;
         c.slot_index = SLOT_W'($urandom_range(0, ssrm_pkg::SLOT_COUNT_DEF - 1));
         if ($urandom_range(0, 9) != 0) c.frame_count_in = FRAME_W'($urandom_range(0, 200));
         c.last_flag  = ($urandom_range(0, 7) == 0);
      end else if (pick < 65) begin
         c.action = ssrm_pkg::ACT_CONSUME;
         if ($urandom_range(0, 19) != 0) c.frames_used = FRAME_W'($urandom_range(0, 80));
      end else if (pick < 82) begin
         c.action = ssrm_pkg::ACT_ADVANCE;
      end else if (pick < 87) begin
         c.action = ssrm_pkg::ACT_SEEK;
         // land inside the track most of the time so advances keep working
         if ($urandom_range(0, 3) != 0) c.target_segment = TAG_W'($urandom_range(0, total));
      end else if (pick < 89) begin
         c.action = ssrm_pkg::ACT_RESET;
      end else if (pick < 93) begin
         c.action = ssrm_pkg::ACT_MARK;
      end
      return c;
   endfunction

   // one command beat; bursts of random length separated by random gaps
   task automatic issue(input ring_cmd_type c);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid          <= 1'b1;
      req_action         <= c.action;
      req_slot_index     <= c.slot_index;
      req_frame_count_in <= c.frame_count_in;
      req_segment_tag_in <= c.segment_tag_in;
      req_last_flag      <= c.last_flag;
      req_frames_used    <= c.frames_used;
      req_target_segment <= c.target_segment;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and wait for every outstanding response beat
   // (the checker's count is registered, hence the first edge)
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // config writes only land on an idle block
   task automatic set_total(input logic [TAG_W-1:0] segments);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= segments;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // receiver: back-pressure in spans of one style each, plus the
   // occasional long hold that backs the block up into its request side
   initial begin : receiver
      int unsigned style;
      int unsigned span;
      int unsigned held;
      logic        toggle;
      rsp_stall <= 1'b0;
      toggle = 1'b0;
      forever begin
         style = $urandom_range(0, 3);
         span  = $urandom_range(20, 150);
         repeat (span) begin
            @(posedge clock);
            if (long_hold_requests != 0 && !reset) begin
               long_hold_requests--;
               rsp_stall <= 1'b1;
               held = 0;
               while (held < LONG_HOLD) begin
                  @(posedge clock);
                  held++;
               end
            end
            toggle = ~toggle;
            case (style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 99) < 30);
               2: rsp_stall <= ($urandom_range(0, 99) < 70);
               default: rsp_stall <= toggle;
            endcase
         end
      end
   end

   initial begin : stimulus
      logic [TAG_W-1:0] phase_total [0:5];
      reset              <= 1'b1;
      csr_write_enable   <= 1'b0;
      csr_write_data     <= '0;
      req_valid          <= 1'b0;
      req_action         <= ssrm_pkg::ACT_MARK;
      req_slot_index     <= '0;
      req_frame_count_in <= '0;
      req_segment_tag_in <= '0;
      req_last_flag      <= 1'b0;
      req_frames_used    <= '0;
      req_target_segment <= '0;
      burst_left         = 0;
      long_hold_requests = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: track length still at its reset value of one
      issue(cmd_of(ssrm_pkg::ACT_CONSUME, 4'd0, 24'd0, 16'd0, 1'b0, 24'hFFFFFF, 16'd0));
      issue(cmd_of(ssrm_pkg::ACT_ADVANCE, 4'd0, 24'd0, 16'd0, 1'b0, 24'd0, 16'd0));
      issue(cmd_of(ssrm_pkg::ACT_MARK, 4'd3, 24'd7, 16'd9, 1'b1, 24'd0, 16'd0)); // bad slot
      issue(cmd_of(ssrm_pkg::ACT_MARK, 4'd15, 24'hFFFFFF, 16'hFFFF, 1'b1, 24'd0, 16'd0));
      issue(cmd_of(ssrm_pkg::ACT_MARK, 4'd0, 24'hFFFFFF, 16'hFFFF, 1'b1, 24'd0, 16'd0));
      issue(cmd_of(ssrm_pkg::ACT_MARK, 4'd1, 24'd0, 16'd0, 1'b0, 24'd0, 16'd0));
      issue(cmd_of(ssrm_pkg::ACT_MARK, 4'd2, 24'd5, 16'h1234, 1'b0, 24'd0, 16'd0));
      issue(cmd_of(ssrm_pkg::ACT_CONSUME, 4'd0, 24'd0, 16'd0, 1'b0, 24'hFFFFFF, 16'd0));
      // saturates
      issue(cmd_of(ssrm_pkg::ACT_CONSUME, 4'd0, 24'd0, 16'd0, 1'b0, 24'hFFFFFF, 16'd0));
      issue(cmd_of(ssrm_pkg::ACT_CONSUME, 4'd0, 24'd0, 16'd0, 1'b0, 24'd0, 16'd0));
      // unused codes with every other field at all ones
      issue(cmd_of(3'd5, 4'hF, 24'hFFFFFF, 16'hFFFF, 1'b1, 24'hFFFFFF, 16'hFFFF));
      issue(cmd_of(3'd6, 4'hF, 24'hFFFFFF, 16'hFFFF, 1'b1, 24'hFFFFFF, 16'hFFFF));
      issue(cmd_of(3'd7, 4'hF, 24'hFFFFFF, 16'hFFFF, 1'b1, 24'hFFFFFF, 16'hFFFF));
      issue(cmd_of(ssrm_pkg::ACT_SEEK, 4'd0, 24'd0, 16'd0, 1'b0, 24'd0, 16'hFFFF));
      issue(cmd_of(ssrm_pkg::ACT_RESET, 4'd0, 24'd0, 16'd0, 1'b0, 24'd0, 16'hFFFF));

      // zero segments: advance is always refused
      set_total(16'd0);
      issue(cmd_of(ssrm_pkg::ACT_MARK, 4'd0, 24'd10, 16'd3, 1'b0, 24'd0, 16'd0));
      issue(cmd_of(ssrm_pkg::ACT_ADVANCE, 4'd0, 24'd0, 16'd0, 1'b0, 24'd0, 16'd0));

      // longest track: one advance left before the end
      set_total(16'hFFFF);
      issue(cmd_of(ssrm_pkg::ACT_SEEK, 4'd0, 24'd0, 16'd0, 1'b0, 24'd0, 16'd65533));
      issue(cmd_of(ssrm_pkg::ACT_MARK, 4'd0, 24'd1, 16'd11, 1'b0, 24'd0, 16'd0));
      issue(cmd_of(ssrm_pkg::ACT_MARK, 4'd1, 24'd2, 16'd12, 1'b1, 24'd0, 16'd0));
      issue(cmd_of(ssrm_pkg::ACT_ADVANCE, 4'd0, 24'd0, 16'd0, 1'b0, 24'd0, 16'd0));
      issue(cmd_of(ssrm_pkg::ACT_ADVANCE, 4'd0, 24'd0, 16'd0, 1'b0, 24'd0, 16'd0));

      // four segments: walk the ring all the way round
      set_total(16'd4);
      issue(cmd_of(ssrm_pkg::ACT_RESET, 4'd0, 24'd0, 16'd0, 1'b0, 24'd0, 16'd0));
      issue(cmd_of(ssrm_pkg::ACT_ADVANCE, 4'd0, 24'd0, 16'd0, 1'b0, 24'd0, 16'd0));
      issue(cmd_of(ssrm_pkg::ACT_ADVANCE, 4'd0, 24'd0, 16'd0, 1'b0, 24'd0, 16'd0));
      issue(cmd_of(ssrm_pkg::ACT_ADVANCE, 4'd0, 24'd0, 16'd0, 1'b0, 24'd0, 16'd0));

      // random playback phases, each under its own track length
      phase_total[0] = 16'hFFFF;
      phase_total[1] = 16'd8;
      phase_total[2] = 16'd3;
      phase_total[3] = TAG_W'($urandom_range(2, 300));
      phase_total[4] = 16'd1;
      phase_total[5] = 16'd16;
      for (int ph = 0; ph < 6; ph++) begin
         set_total(phase_total[ph]);
         // receiver sits on its output while commands keep coming
         if (ph == 1 || ph == 4) long_hold_requests = 1;
         repeat (PHASE_BEATS) issue(playback_cmd(phase_total[ph]));
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
